>>> sv/icpg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icpg_pkg
// Shared types, codes and sizes of the im2col patch generator.
// ----------------------------------------------------------------------------
package icpg_pkg;

  localparam int unsigned IMAGE_WORDS   = 4096;
  localparam int unsigned WORD_BITS     = 32;
  localparam int unsigned IDX_BITS      = $clog2(IMAGE_WORDS);
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 7;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_EMIT    = 2'd1,
    MODE_RESTART = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_NUM_CHANNELS  = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_IMAGE_WIDTH   = 3'd2,
    CFG_KERNEL_HEIGHT = 3'd3,
    CFG_KERNEL_WIDTH  = 3'd4,
    CFG_PAD_AMOUNT    = 3'd5,
    CFG_STRIDE_ROWS   = 3'd6,
    CFG_STRIDE_COLS   = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_OFFS,
    ST_ADDR,
    ST_DATA
  } state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] pixel_word;
  } in_word_t;

  typedef struct packed {
    logic [31:0] element_value;
    logic        is_padding;
    logic [11:0] source_index;
    logic        row_end;
    logic        matrix_end;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic mul;
    logic offs;
    logic rd;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic geom_ok;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

>>> sv/im2col_patch_generator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// im2col_patch_generator_core
// Streams the im2col matrix of one stored image, one element per emit word.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) carries a mode and a
// pixel. A load word writes the pixel into the image store at the load
// pointer, and a restart word clears the pointer and the scan counters;
// neither blocks the next word. An emit word, when the kernel fits the
// padded image, makes one output word: two arithmetic stages form the
// source index, the store read is registered, and the output register is
// filled last. The block takes a new word only after the emit has left the
// sequencer, so a new emit is not taken before the last one is through.
// Output channel (out_valid_o / out_ready_i / out_data_o) is a register; a
// stalled receiver holds the word and the next emit waits in its last step.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take effect at
// once; the user must make them while the block is idle (it does not check).
// Reset clears the counters, the load pointer and the output valid, and sets
// the registers to their defaults; the image store is not cleared.
// ----------------------------------------------------------------------------
module im2col_patch_generator_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [icpg_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [icpg_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire icpg_pkg::in_word_t                 in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output icpg_pkg::out_word_t                     out_data_o
);
  import icpg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  icpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (in_data_i.mode),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  icpg_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pixel_word_i (in_data_i.pixel_word),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // load and restart words never block the next word
  a_short_ops_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_data_i.mode != MODE_EMIT)) |=> in_ready_o)
    else $error("input blocked after load or restart");

  // a valid emit keeps the sequencer busy
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_data_i.mode == MODE_EMIT) && status.geom_ok)
    |=> !in_ready_o)
    else $error("input ready during emit");

  // a new output word comes only from a finished emit
  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.finish))
    else $error("output word without finished emit");

  // padding words carry zero data and index
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.is_padding) |->
    ((out_data_o.element_value == 32'd0) && (out_data_o.source_index == 12'd0)))
    else $error("padding word with nonzero fields");

endmodule
`default_nettype wire

>>> sv/icpg_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icpg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module icpg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> sv/icpg_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icpg_ctrl
// Sequencer: takes input words and steps the datapath through one emit.
// ----------------------------------------------------------------------------
module icpg_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           mode_i,
  input  wire icpg_pkg::dp_status_t status_i,
  output icpg_pkg::dp_cmd_t         cmd_o
);
  import icpg_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (mode_i)
            MODE_LOAD:    cmd_o.load = 1'b1;
            MODE_RESTART: cmd_o.restart = 1'b1;
            MODE_EMIT: begin
              if (status_i.geom_ok) begin
                state_d = ST_MUL;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_OFFS;
      end
      ST_OFFS: begin
        cmd_o.offs = 1'b1;
        state_d    = ST_ADDR;
      end
      ST_ADDR: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_DATA;
      end
      ST_DATA: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/icpg_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icpg_datapath
// Config registers, scan counters, address arithmetic, image store, output.
// ----------------------------------------------------------------------------
module icpg_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [icpg_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [icpg_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  input  wire logic [31:0]                         pixel_word_i,
  input  wire icpg_pkg::dp_cmd_t                   cmd_i,
  output icpg_pkg::dp_status_t                     status_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output icpg_pkg::out_word_t                      out_data_o
);
  import icpg_pkg::*;

  function automatic logic [6:0] clamp_cfg(input logic [6:0] v, input logic [6:0] hi);
    logic [6:0] r;
    r = v;
    if (v == 7'd0) begin
      r = 7'd1;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  // config registers
  logic [6:0] nc_q, ih_q, iw_q;
  logic [4:0] kh_q, kw_q;
  logic [3:0] pd_q, sr_q, sc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q <= 7'd1;
      ih_q <= 7'd1;
      iw_q <= 7'd1;
      kh_q <= 5'd1;
      kw_q <= 5'd1;
      pd_q <= 4'd0;
      sr_q <= 4'd1;
      sc_q <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_NUM_CHANNELS:  nc_q <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT:  ih_q <= cfg_wdata_i;
        CFG_IMAGE_WIDTH:   iw_q <= cfg_wdata_i;
        CFG_KERNEL_HEIGHT: kh_q <= cfg_wdata_i[4:0];
        CFG_KERNEL_WIDTH:  kw_q <= cfg_wdata_i[4:0];
        CFG_PAD_AMOUNT:    pd_q <= cfg_wdata_i[3:0];
        CFG_STRIDE_ROWS:   sr_q <= cfg_wdata_i[3:0];
        CFG_STRIDE_COLS:   sc_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // clamped view of the registers
  logic [6:0] nc, ih, iw;
  logic [4:0] kh, kw;
  logic [3:0] sr, sc;
  logic [7:0] ph, pw;

  always_comb begin
    nc = clamp_cfg(nc_q, 7'd64);
    ih = clamp_cfg(ih_q, 7'd64);
    iw = clamp_cfg(iw_q, 7'd64);
    kh = 5'(clamp_cfg(7'(kh_q), 7'd16));
    kw = 5'(clamp_cfg(7'(kw_q), 7'd16));
    sr = 4'(clamp_cfg(7'(sr_q), 7'd8));
    sc = 4'(clamp_cfg(7'(sc_q), 7'd8));
    ph = 8'(ih) + 8'({pd_q, 1'b0});
    pw = 8'(iw) + 8'({pd_q, 1'b0});
  end

  // scan counters and load pointer
  logic [IDX_BITS-1:0] ptr_q;
  logic [6:0]          orow_q, ocol_q;
  logic [5:0]          ch_q;
  logic [3:0]          kr_q, kc_q;

  // pipeline registers of one emit
  logic [10:0]         prow_q, pcol_q;
  logic [IDX_BITS-1:0] chh_q, chw_q, rowoff_q, colrel_q, src_q;
  logic                kc_last_q, kr_last_q, ch_last_q, oc_last_q, or_last_q, pad_q;

  logic [10:0]         rrel, crel;
  logic                in_row, in_col;
  logic [IDX_BITS-1:0] src;
  logic [WORD_BITS-1:0] rdata;

  assign rrel   = prow_q - 11'(pd_q);
  assign crel   = pcol_q - 11'(pd_q);
  assign in_row = (prow_q >= 11'(pd_q)) && (rrel < 11'(ih));
  assign in_col = (pcol_q >= 11'(pd_q)) && (crel < 11'(iw));
  assign src    = chw_q + rowoff_q + colrel_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prow_q    <= 11'(orow_q) * 11'(sr) + 11'(kr_q);
      pcol_q    <= 11'(ocol_q) * 11'(sc) + 11'(kc_q);
      chh_q     <= IDX_BITS'(ch_q) * IDX_BITS'(ih);
      kc_last_q <= (5'(kc_q) + 5'd1) >= kw;
      kr_last_q <= (5'(kr_q) + 5'd1) >= kh;
      ch_last_q <= (7'(ch_q) + 7'd1) >= nc;
      oc_last_q <= (12'(ocol_q) + 12'd1) * 12'(sc) + 12'(kw) > 12'(pw);
      or_last_q <= (12'(orow_q) + 12'd1) * 12'(sr) + 12'(kh) > 12'(ph);
    end
    if (cmd_i.offs) begin
      pad_q    <= !(in_row && in_col);
      chw_q    <= chh_q * IDX_BITS'(iw);
      rowoff_q <= IDX_BITS'(rrel) * IDX_BITS'(iw);
      colrel_q <= IDX_BITS'(crel);
    end
    if (cmd_i.rd) begin
      src_q <= pad_q ? '0 : src;
    end
  end

  icpg_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (IMAGE_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (ptr_q),
    .wdata_i (WORD_BITS'(pixel_word_i)),
    .re_i    (cmd_i.rd),
    .raddr_i (src),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      orow_q <= '0;
      ocol_q <= '0;
      ch_q   <= '0;
      kr_q   <= '0;
      kc_q   <= '0;
    end else if (cmd_i.restart) begin
      ptr_q  <= '0;
      orow_q <= '0;
      ocol_q <= '0;
      ch_q   <= '0;
      kr_q   <= '0;
      kc_q   <= '0;
    end else if (cmd_i.load) begin
      ptr_q <= ptr_q + 1'b1;
    end else if (cmd_i.finish) begin
      if (!kc_last_q) begin
        kc_q <= kc_q + 4'd1;
      end else begin
        kc_q <= '0;
        if (!kr_last_q) begin
          kr_q <= kr_q + 4'd1;
        end else begin
          kr_q <= '0;
          if (!ch_last_q) begin
            ch_q <= ch_q + 6'd1;
          end else begin
            ch_q <= '0;
            if (!oc_last_q) begin
              ocol_q <= ocol_q + 7'd1;
            end else begin
              ocol_q <= '0;
              orow_q <= or_last_q ? 7'd0 : orow_q + 7'd1;
            end
          end
        end
      end
    end
  end

  // output word register
  logic      out_valid_q;
  out_word_t out_q;
  logic      rend;

  assign rend = kc_last_q && kr_last_q && ch_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.element_value <= pad_q ? 32'd0 : 32'(rdata);
      out_q.is_padding    <= pad_q;
      out_q.source_index  <= 12'(src_q);
      out_q.row_end       <= rend;
      out_q.matrix_end    <= rend && oc_last_q && or_last_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign status_o.geom_ok  = (8'(kh) <= ph) && (8'(kw) <= pw);
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule
`default_nettype wire
